### sv/rtb_pkg.sv
// Package: shared types, codes and helpers of the remote trigger beacon transmitter.
`default_nettype none

package rtb_pkg;

  // Event codes carried by an input request
  typedef enum logic [1:0] {
    KIND_TICK     = 2'd0,
    KIND_SAMPLE   = 2'd1,
    KIND_RX       = 2'd2,
    KIND_TX_READY = 2'd3
  } rtb_kind_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_ANALOG_MODE = 2'd0,
    CFG_SALT        = 2'd1,
    CFG_BOTH_TH     = 2'd2,
    CFG_FOCUS_TH    = 2'd3
  } rtb_cfg_idx_t;

  // Beacon send sequencer; encoding 3 is unused and acts as idle
  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_SYNC = 2'd1,
    PH_CODE = 2'd2
  } rtb_phase_t;

  localparam int unsigned KIND_W    = 2;
  localparam int unsigned PEDAL_W   = 2;
  localparam int unsigned SAMPLE_W  = 10;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned SUM_W     = 16;
  localparam int unsigned CNT_W     = 6;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [BYTE_W-1:0]  SYNC_BYTE      = 8'hFF;
  localparam logic [CNT_W-1:0]   LAST_SAMPLE    = 6'd63;

  localparam logic [PEDAL_W-1:0] PEDAL_BOTH     = 2'd0;
  localparam logic [PEDAL_W-1:0] PEDAL_FOCUS    = 2'd1;
  localparam logic [PEDAL_W-1:0] PEDAL_RELEASED = 2'd3;

  localparam logic              RST_ANALOG_MODE = 1'b1;
  localparam logic [BYTE_W-1:0] RST_SALT        = 8'd216;
  localparam logic [BYTE_W-1:0] RST_BOTH_TH     = 8'd64;
  localparam logic [BYTE_W-1:0] RST_FOCUS_TH    = 8'd110;

  // Pedal bits repeated across the byte, then salted
  function automatic logic [BYTE_W-1:0] code_byte(input logic [PEDAL_W-1:0] pedal,
                                                  input logic [BYTE_W-1:0]  salt);
    code_byte = {4{pedal}} ^ salt;
  endfunction

endpackage

`default_nettype wire

### sv/rtb_if.sv
// Interfaces: input event, result and configuration channels of the beacon transmitter.
`default_nettype none

interface rtb_in_if;
  import rtb_pkg::*;
  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [PEDAL_W-1:0]  pedal_bits;
  logic [SAMPLE_W-1:0] sample;
  logic [BYTE_W-1:0]   rx_byte;
  modport source (output valid, kind, pedal_bits, sample, rx_byte, input ready);
  modport sink   (input valid, kind, pedal_bits, sample, rx_byte, output ready);
endinterface

interface rtb_out_if;
  import rtb_pkg::*;
  logic              valid;
  logic              ready;
  logic              tx_valid;
  logic [BYTE_W-1:0] tx_byte;
  logic              led_on;
  logic              acked;
  modport source (output valid, tx_valid, tx_byte, led_on, acked, input ready);
  modport sink   (input valid, tx_valid, tx_byte, led_on, acked, output ready);
endinterface

interface rtb_cfg_if;
  import rtb_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [BYTE_W-1:0]    data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### sv/remote_trigger_beacon_tx_core.sv
// Top level: remote trigger beacon transmitter, pedal tracking, beacon send and ack watch.
// A request accepted into the input register moves on to the result register, which drives out_if.
// Throughput: one request per cycle while results are taken; an input register and a result
//   register hold the two halves, so a stalled result still lets one request in.
// Reset (rst_n low, synchronous): drops both pipeline registers, reloads config
//   defaults, pedal released, LED on, ack cleared, beacon idle.
`default_nettype none

module remote_trigger_beacon_tx_core (
  input  logic  clk,
  input  logic  rst_n,
  rtb_in_if.sink    in_if,
  rtb_out_if.source out_if,
  rtb_cfg_if.sink   cfg_if
);
  import rtb_pkg::*;

  // Configuration registers
  logic              analog_mode_r;
  logic [BYTE_W-1:0] salt_r;
  logic [BYTE_W-1:0] both_th_r;
  logic [BYTE_W-1:0] focus_th_r;

  // Input register
  logic                s1_valid_r;
  rtb_kind_t           s1_kind_r;
  logic [PEDAL_W-1:0]  s1_bits_r;
  logic [SAMPLE_W-1:0] s1_sample_r;
  logic [BYTE_W-1:0]   s1_rx_r;

  // Block state
  logic [SUM_W-1:0]   level_sum_r,  level_sum_nxt;
  logic [CNT_W-1:0]   sample_cnt_r, sample_cnt_nxt;
  logic [PEDAL_W-1:0] pedal_now_r,  pedal_now_nxt;
  logic [BYTE_W-1:0]  last_code_r,  last_code_nxt;
  logic               ack_seen_r,   ack_seen_nxt;
  rtb_phase_t         phase_r,      phase_nxt;
  logic               listen_r,     listen_nxt;
  logic               lamp_r,       lamp_nxt;

  // Result register
  logic              out_valid_r;
  logic              tx_valid_r,   tx_valid_nxt;
  logic [BYTE_W-1:0] tx_byte_r,    tx_byte_nxt;
  logic              led_r;
  logic              acked_r;

  // Working values of the single pass
  logic               judge;
  logic [PEDAL_W-1:0] pedal_new;
  logic [SUM_W-1:0]   sum_add;
  logic [BYTE_W-1:0]  avg;
  logic [BYTE_W-1:0]  code;

  logic adv;      // result register can take the input register's item
  logic s1_fire;  // input register item is processed this cycle

  assign adv     = !out_valid_r || out_if.ready;
  assign s1_fire = s1_valid_r && adv;

  assign in_if.ready  = !s1_valid_r || adv;
  assign cfg_if.ready = 1'b1;

  // Configuration writes; the user must change config only while the block is idle, the block does not enforce it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      analog_mode_r <= RST_ANALOG_MODE;
      salt_r        <= RST_SALT;
      both_th_r     <= RST_BOTH_TH;
      focus_th_r    <= RST_FOCUS_TH;
    end else if (cfg_if.valid) begin
      unique case (rtb_cfg_idx_t'(cfg_if.index))
        CFG_ANALOG_MODE: analog_mode_r <= cfg_if.data[0];
        CFG_SALT:        salt_r        <= cfg_if.data;
        CFG_BOTH_TH:     both_th_r     <= cfg_if.data;
        CFG_FOCUS_TH:    focus_th_r    <= cfg_if.data;
        default:         ;
      endcase
    end
  end

  // Input register: take a request whenever the stage is empty or moving on
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_if.ready) begin
      s1_valid_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.ready && in_if.valid) begin
      s1_kind_r   <= rtb_kind_t'(in_if.kind);
      s1_bits_r   <= in_if.pedal_bits;
      s1_sample_r <= in_if.sample;
      s1_rx_r     <= in_if.rx_byte;
    end
  end

  // Per-event update of the block state
  always_comb begin
    level_sum_nxt  = level_sum_r;
    sample_cnt_nxt = sample_cnt_r;
    pedal_now_nxt  = pedal_now_r;
    last_code_nxt  = last_code_r;
    ack_seen_nxt   = ack_seen_r;
    phase_nxt      = phase_r;
    listen_nxt     = listen_r;
    lamp_nxt       = lamp_r;
    tx_valid_nxt   = 1'b0;
    tx_byte_nxt    = '0;
    judge          = 1'b0;
    pedal_new      = pedal_now_r;
    sum_add        = level_sum_r + SUM_W'(s1_sample_r);
    avg            = sum_add[SUM_W-1 -: BYTE_W];
    code           = code_byte(pedal_now_r, salt_r);

    unique case (s1_kind_r)
      KIND_TICK: begin
        // Digital mode samples the port bits; analog mode leaves the state unchanged
        if (!analog_mode_r) begin
          pedal_new = s1_bits_r;
          judge     = 1'b1;
        end
      end
      KIND_SAMPLE: begin
        if (analog_mode_r) begin
          if (sample_cnt_r == LAST_SAMPLE) begin
            // Sum of 64 samples over 256; both threshold wins ties in order
            if (avg < both_th_r) begin
              pedal_new = PEDAL_BOTH;
            end else if (avg < focus_th_r) begin
              pedal_new = PEDAL_FOCUS;
            end else begin
              pedal_new = PEDAL_RELEASED;
            end
            judge          = 1'b1;
            level_sum_nxt  = '0;
            sample_cnt_nxt = '0;
          end else begin
            level_sum_nxt  = sum_add;
            sample_cnt_nxt = sample_cnt_r + 1'b1;
          end
        end
      end
      KIND_RX: begin
        // Ack watcher: sync byte, then the last code sent
        if (!listen_r) begin
          if (s1_rx_r == SYNC_BYTE) begin
            listen_nxt = 1'b1;
          end
        end else begin
          if (s1_rx_r == last_code_r) begin
            ack_seen_nxt = 1'b1;
          end
          listen_nxt = 1'b0;
        end
      end
      KIND_TX_READY: begin
        case (phase_r)
          PH_SYNC: begin
            tx_valid_nxt = 1'b1;
            tx_byte_nxt  = SYNC_BYTE;
            phase_nxt    = PH_CODE;
          end
          PH_CODE: begin
            tx_valid_nxt  = 1'b1;
            tx_byte_nxt   = code;
            last_code_nxt = code;
            phase_nxt     = PH_IDLE;
          end
          default: begin
            phase_nxt = PH_IDLE;
          end
        endcase
      end
      default: ;
    endcase

    // New pedal reading: restart the beacon and blink on change or missing ack, else light the LED
    if (judge) begin
      pedal_now_nxt = pedal_new;
      if (pedal_new != pedal_now_r || !ack_seen_r) begin
        ack_seen_nxt = 1'b0;
        phase_nxt    = PH_SYNC;
        lamp_nxt     = !lamp_r;
      end else begin
        lamp_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_sum_r  <= '0;
      sample_cnt_r <= '0;
      pedal_now_r  <= PEDAL_RELEASED;
      last_code_r  <= '0;
      ack_seen_r   <= 1'b0;
      phase_r      <= PH_IDLE;
      listen_r     <= 1'b0;
      lamp_r       <= 1'b1;
    end else if (s1_fire) begin
      level_sum_r  <= level_sum_nxt;
      sample_cnt_r <= sample_cnt_nxt;
      pedal_now_r  <= pedal_now_nxt;
      last_code_r  <= last_code_nxt;
      ack_seen_r   <= ack_seen_nxt;
      phase_r      <= phase_nxt;
      listen_r     <= listen_nxt;
      lamp_r       <= lamp_nxt;
    end
  end

  // Result register: advance when empty or being taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      tx_valid_r <= tx_valid_nxt;
      tx_byte_r  <= tx_byte_nxt;
      led_r      <= lamp_nxt;
      acked_r    <= ack_seen_nxt;
    end
  end

  assign out_if.valid    = out_valid_r;
  assign out_if.tx_valid = tx_valid_r;
  assign out_if.tx_byte  = tx_byte_r;
  assign out_if.led_on   = led_r;
  assign out_if.acked    = acked_r;

endmodule

`default_nettype wire

### sv/rtb_checker.sv
// Checker: port-level assertions for the beacon transmitter, bound to the top level.
`default_nettype none

module rtb_checker (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  logic                      out_tx_valid,
  input  logic [rtb_pkg::BYTE_W-1:0] out_tx_byte,
  input  logic                      out_led_on,
  input  logic                      out_acked
);
  import rtb_pkg::*;

  // Reset drops any pending result
  a_reset_drop: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // A stalled result holds its payload
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_tx_valid) && $stable(out_tx_byte)
      && $stable(out_led_on) && $stable(out_acked))
    else $error("stalled result changed");

  // No byte to send means an all-zero byte
  a_quiet_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_tx_valid |-> out_tx_byte == '0)
    else $error("tx_byte nonzero without tx_valid");

  // A fresh result follows a request accepted through the input register
  a_origin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result without a matching request");

endmodule

bind remote_trigger_beacon_tx_core rtb_checker u_rtb_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_if.valid),
  .in_ready     (in_if.ready),
  .out_valid    (out_if.valid),
  .out_ready    (out_if.ready),
  .out_tx_valid (out_if.tx_valid),
  .out_tx_byte  (out_if.tx_byte),
  .out_led_on   (out_if.led_on),
  .out_acked    (out_if.acked)
);

`default_nettype wire

### bench/remote_trigger_beacon_tx_core_test.sv
// Self-checking bench for the beacon transmitter: pedal tracking, beacon send, ack watch.
`default_nettype none

module remote_trigger_beacon_tx_core_test;
  import rtb_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  // One input request as the block sees it
  typedef struct packed {
    rtb_kind_t           kind;
    logic [PEDAL_W-1:0]  pedal_bits;
    logic [SAMPLE_W-1:0] sample;
    logic [BYTE_W-1:0]   rx_byte;
  } beacon_ev_t;

  // One result of the block
  typedef struct packed {
    logic              tx_valid;
    logic [BYTE_W-1:0] tx_byte;
    logic              led_on;
    logic              acked;
  } beacon_out_t;

  // Pending request; echo asks the driver to fill rx_byte with the last code sent
  typedef struct {
    beacon_ev_t ev;
    bit         echo;
  } pend_t;

  logic clk;
  logic rst_n;

  rtb_in_if  in_bus ();
  rtb_out_if out_bus ();
  rtb_cfg_if cfg_bus ();

  remote_trigger_beacon_tx_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_bus),
    .out_if (out_bus),
    .cfg_if (cfg_bus)
  );

  always #10 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Beacon predictor: its own copy of the registers and the pedal/beacon state
  // ---------------------------------------------------------------------------
  logic              mode_analog;
  logic [BYTE_W-1:0] salt_r;
  logic [BYTE_W-1:0] th_both;
  logic [BYTE_W-1:0] th_focus;

  logic [SUM_W-1:0]   sum_acc;
  logic [CNT_W-1:0]   count_acc;
  logic [PEDAL_W-1:0] pedal_cur;
  logic [PEDAL_W-1:0] pedal_prev;
  logic [BYTE_W-1:0]  code_sent;
  logic               ack_flag;
  rtb_phase_t         send_state;
  logic               sync_heard;
  logic               led;

  // Expected results in order of acceptance, and requests waiting to go out
  beacon_out_t beacon_q[$];
  pend_t       pend_q[$];

  int n_errors  = 0;
  int n_items   = 0;
  int n_results = 0;
  int n_sent    = 0;
  int n_cfg     = 0;
  int n_restart = 0;
  int n_settle  = 0;
  int n_ack     = 0;
  int n_drain   = 0;
  int cycles    = 0;

  function automatic void reset_beacon_model();
    mode_analog = RST_ANALOG_MODE;
    salt_r      = RST_SALT;
    th_both     = RST_BOTH_TH;
    th_focus    = RST_FOCUS_TH;
    sum_acc     = '0;
    count_acc   = '0;
    pedal_cur   = PEDAL_RELEASED;
    pedal_prev  = PEDAL_RELEASED;
    code_sent   = '0;
    ack_flag    = 1'b0;
    send_state  = PH_IDLE;
    sync_heard  = 1'b0;
    led         = 1'b1;
  endfunction

  // A new pedal decision: restart the beacon on change or missing ack, else light the LED
  function automatic void settle_or_restart();
    if (pedal_cur != pedal_prev || !ack_flag) begin
      ack_flag   = 1'b0;
      pedal_prev = pedal_cur;
      send_state = PH_SYNC;
      led        = ~led;
      n_restart++;
    end else begin
      led = 1'b1;
      n_settle++;
    end
  endfunction

  function automatic beacon_out_t beacon_step(input beacon_ev_t ev);
    beacon_out_t r;
    r = '0;
    case (ev.kind)
      KIND_TICK: begin
        // a tick in analog mode leaves the state unchanged
        if (!mode_analog) begin
          pedal_prev = pedal_cur;
          pedal_cur  = ev.pedal_bits;
          settle_or_restart();
        end
      end
      KIND_SAMPLE: begin
        if (mode_analog) begin
          sum_acc = sum_acc + ev.sample;
          if (count_acc == LAST_SAMPLE) begin
            // average is the sum over 256; the both threshold wins whatever the order
            pedal_prev = pedal_cur;
            if (sum_acc[SUM_W-1:8] < th_both)
              pedal_cur = PEDAL_BOTH;
            else if (sum_acc[SUM_W-1:8] < th_focus)
              pedal_cur = PEDAL_FOCUS;
            else
              pedal_cur = PEDAL_RELEASED;
            settle_or_restart();
            sum_acc   = '0;
            count_acc = '0;
          end else begin
            count_acc = count_acc + 1'b1;
          end
        end
      end
      KIND_RX: begin
        // a byte after a sync acks if it is the code, and drops the watcher back to waiting either way
        if (!sync_heard) begin
          sync_heard = (ev.rx_byte == SYNC_BYTE);
        end else begin
          if (ev.rx_byte == code_sent) begin
            ack_flag = 1'b1;
            n_ack++;
          end
          sync_heard = 1'b0;
        end
      end
      KIND_TX_READY: begin
        case (send_state)
          PH_SYNC: begin
            r.tx_valid = 1'b1;
            r.tx_byte  = SYNC_BYTE;
            send_state = PH_CODE;
          end
          PH_CODE: begin
            code_sent  = {pedal_cur, pedal_cur, pedal_cur, pedal_cur} ^ salt_r;
            r.tx_valid = 1'b1;
            r.tx_byte  = code_sent;
            send_state = PH_IDLE;
          end
          default: send_state = PH_IDLE;
        endcase
      end
      default: ;
    endcase
    r.led_on = led;
    r.acked  = ack_flag;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Request generator
  // ---------------------------------------------------------------------------
  bit                 gen_mode;
  int                 gen_cnt;
  int                 gen_level;
  logic [PEDAL_W-1:0] gen_bits;

  // Queue one request; return 1 when the block acts on it
  function automatic int queue_event(input rtb_kind_t kind, input int bits, input int smp,
                                     input int rx, input bit echo);
    pend_t p;
    p.ev.kind       = kind;
    p.ev.pedal_bits = bits[PEDAL_W-1:0];
    p.ev.sample     = smp[SAMPLE_W-1:0];
    p.ev.rx_byte    = rx[BYTE_W-1:0];
    p.echo          = echo;
    pend_q.push_back(p);
    if (kind == KIND_TICK)
      return gen_mode ? 0 : 1;
    if (kind == KIND_SAMPLE) begin
      if (!gen_mode)
        return 0;
      gen_cnt = (gen_cnt + 1) % 64;
    end
    return 1;
  endfunction

  function automatic int rnd_byte();
    return $urandom_range(0, 255);
  endfunction

  function automatic int rnd_sample();
    return $urandom_range(0, 1023);
  endfunction

  // Complete the current averaging window around one level, or with raw samples
  function automatic int analog_frame(input bit keep_level);
    int n;
    int left;
    int s;
    bit raw;
    n    = 0;
    left = 64 - gen_cnt;
    raw  = ($urandom_range(0, 3) == 0);
    if (!keep_level)
      gen_level = $urandom_range(0, 1023);
    repeat (left) begin
      s = raw ? rnd_sample() : gen_level + $urandom_range(0, 16) - 8;
      if (s < 0)
        s = 0;
      if (s > 1023)
        s = 1023;
      n += queue_event(KIND_SAMPLE, $urandom_range(0, 3), s, rnd_byte(), 1'b0);
    end
    return n;
  endfunction

  // Pedal decision, beacon send and, mostly, a proper ack from the far end
  function automatic int beacon_round();
    int n;
    int tx_n;
    n = 0;
    if (gen_mode) begin
      n += analog_frame($urandom_range(0, 1));
    end else begin
      if ($urandom_range(0, 1))
        gen_bits = PEDAL_W'($urandom_range(0, 3));
      n += queue_event(KIND_TICK, gen_bits, rnd_sample(), rnd_byte(), 1'b0);
    end
    tx_n = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 3) : 2;
    repeat (tx_n)
      n += queue_event(KIND_TX_READY, $urandom_range(0, 3), rnd_sample(), rnd_byte(), 1'b0);
    case ($urandom_range(0, 7))
      0: ;
      1: begin
        n += queue_event(KIND_RX, $urandom_range(0, 3), rnd_sample(), SYNC_BYTE, 1'b0);
        n += queue_event(KIND_RX, $urandom_range(0, 3), rnd_sample(), rnd_byte(), 1'b0);
      end
      default: begin
        n += queue_event(KIND_RX, $urandom_range(0, 3), rnd_sample(), SYNC_BYTE, 1'b0);
        n += queue_event(KIND_RX, $urandom_range(0, 3), rnd_sample(), 0, 1'b1);
      end
    endcase
    return n;
  endfunction

  function automatic int noise_event();
    rtb_kind_t k;
    k = rtb_kind_t'($urandom_range(0, 3));
    return queue_event(k, $urandom_range(0, 3), rnd_sample(),
                       ($urandom_range(0, 3) == 0) ? SYNC_BYTE : rnd_byte(), 1'b0);
  endfunction

  function automatic void fill_phase(input int budget);
    int made;
    made = 0;
    while (made < budget) begin
      if ($urandom_range(0, 9) < 7)
        made += beacon_round();
      else
        made += noise_event();
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Input driver: change on the falling edge, hold until accepted
  // ---------------------------------------------------------------------------
  bit in_taken   = 0;
  bit no_idle    = 0;
  bit drain_wait = 0;
  int in_gap     = 0;
  int in_calm    = 0;
  int out_stall  = 0;
  int out_calm   = 0;

  always @(negedge clk) begin : in_driver
    pend_t nxt;
    if (in_calm != 0)
      in_calm <= in_calm - 1;
    else if ($urandom_range(0, 59) == 0)
      in_calm <= $urandom_range(20, 80);
    if (rst_n) begin
      if (in_bus.valid && !in_taken) begin
        // hold the request until the block takes it
      end else if (in_gap != 0) begin
        in_bus.valid <= 1'b0;
        in_gap       <= in_gap - 1;
      end else if (drain_wait) begin
        // pause until every expected result is back
        in_bus.valid <= 1'b0;
        if (beacon_q.size() == 0)
          drain_wait <= 1'b0;
      end else if (pend_q.size() != 0) begin
        if (!no_idle && in_calm == 0 && $urandom_range(0, 7) == 0) begin
          in_bus.valid <= 1'b0;
          in_gap       <= $urandom_range(0, 10);
        end else if (!no_idle && $urandom_range(0, 119) == 0) begin
          in_bus.valid <= 1'b0;
          drain_wait   <= 1'b1;
          n_drain++;
        end else begin
          nxt = pend_q.pop_front();
          in_bus.valid      <= 1'b1;
          in_bus.kind       <= nxt.ev.kind;
          in_bus.pedal_bits <= nxt.ev.pedal_bits;
          in_bus.sample     <= nxt.ev.sample;
          // echo the code as last sent, so the far end acks what is really on air
          in_bus.rx_byte    <= nxt.echo ? code_sent : nxt.ev.rx_byte;
        end
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
  end

  // Result side back-pressure: random stall bursts with calm stretches in between
  always @(negedge clk) begin
    if (out_calm != 0)
      out_calm <= out_calm - 1;
    else if ($urandom_range(0, 49) == 0)
      out_calm <= $urandom_range(20, 90);
    if (out_stall != 0) begin
      out_bus.ready <= 1'b0;
      out_stall     <= out_stall - 1;
    end else if (!no_idle && out_calm == 0 && $urandom_range(0, 5) == 0) begin
      out_bus.ready <= 1'b0;
      out_stall     <= $urandom_range(0, 10);
    end else begin
      out_bus.ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: check results, then predict for the request taken at this edge
  // ---------------------------------------------------------------------------
  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $display("%0t: mismatch on %s: expected 0x%0h, actual 0x%0h", $time, name, want, got);
      n_errors++;
    end
  endfunction

  always @(posedge clk) begin : monitor
    beacon_out_t want;
    beacon_ev_t  ev;
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_bus.valid && in_bus.ready;
      if (out_bus.valid && out_bus.ready) begin
        n_results++;
        if (out_bus.tx_valid)
          n_sent++;
        if (beacon_q.size() == 0) begin
          $display("%0t: result with nothing expected: expected none, actual %0h/%0h/%0h/%0h",
                   $time, out_bus.tx_valid, out_bus.tx_byte, out_bus.led_on, out_bus.acked);
          n_errors++;
        end else begin
          want = beacon_q.pop_front();
          check_field("tx_valid", want.tx_valid, out_bus.tx_valid);
          check_field("tx_byte",  want.tx_byte,  out_bus.tx_byte);
          check_field("led_on",   want.led_on,   out_bus.led_on);
          check_field("acked",    want.acked,    out_bus.acked);
        end
      end
      if (in_bus.valid && in_bus.ready) begin
        ev.kind       = rtb_kind_t'(in_bus.kind);
        ev.pedal_bits = in_bus.pedal_bits;
        ev.sample     = in_bus.sample;
        ev.rx_byte    = in_bus.rx_byte;
        beacon_q.push_back(beacon_step(ev));
        n_items++;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results still expected", $time, beacon_q.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencing
  // ---------------------------------------------------------------------------

  // Wait until every request is out and every result is back, then let the pipe settle
  task automatic wait_drained();
    do @(posedge clk);
    while (pend_q.size() != 0 || in_bus.valid || beacon_q.size() != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input rtb_cfg_idx_t idx, input logic [BYTE_W-1:0] val);
    @(negedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= val;
    do @(posedge clk);
    while (!cfg_bus.ready);
    case (idx)
      CFG_ANALOG_MODE: mode_analog = val[0];
      CFG_SALT:        salt_r      = val;
      CFG_BOTH_TH:     th_both     = val;
      CFG_FOCUS_TH:    th_focus    = val;
      default: ;
    endcase
    n_cfg++;
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic set_regs(input bit analog, input int salt_v, input int both_v,
                          input int focus_v);
    write_reg(CFG_ANALOG_MODE, {7'd0, analog});
    write_reg(CFG_SALT, salt_v[BYTE_W-1:0]);
    write_reg(CFG_BOTH_TH, both_v[BYTE_W-1:0]);
    write_reg(CFG_FOCUS_TH, focus_v[BYTE_W-1:0]);
    gen_mode = analog;
  endtask

  initial begin : stimulus
    int d;
    clk               = 1'b0;
    rst_n             = 1'b0;
    in_bus.valid      = 1'b0;
    in_bus.kind       = '0;
    in_bus.pedal_bits = '0;
    in_bus.sample     = '0;
    in_bus.rx_byte    = '0;
    out_bus.ready     = 1'b0;
    cfg_bus.valid     = 1'b0;
    cfg_bus.index     = CFG_ANALOG_MODE;
    cfg_bus.data      = '0;
    reset_beacon_model();
    gen_mode  = RST_ANALOG_MODE;
    gen_cnt   = 0;
    gen_level = 0;
    gen_bits  = PEDAL_RELEASED;
    d         = 0;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed, default registers (analog mode)
    d += queue_event(KIND_TX_READY, 0, 0, 0, 1'b0);         // ready while idle: nothing sent
    d += queue_event(KIND_TICK, 2, 0, 0, 1'b0);             // tick in analog mode: no effect
    d += queue_event(KIND_RX, 0, 0, SYNC_BYTE, 1'b0);
    d += queue_event(KIND_RX, 0, 0, SYNC_BYTE, 1'b0);       // wrong code, not a new sync
    d += queue_event(KIND_RX, 0, 0, 0, 1'b1);               // still waiting for sync
    d += queue_event(KIND_RX, 3, 1023, SYNC_BYTE, 1'b0);
    d += queue_event(KIND_RX, 0, 0, 0, 1'b1);               // ack of the reset code
    d += queue_event(KIND_SAMPLE, 0, 0, 0, 1'b0);
    d += queue_event(KIND_SAMPLE, 3, 1023, 255, 1'b0);
    wait_drained();

    // Directed, digital mode
    set_regs(1'b0, RST_SALT, RST_BOTH_TH, RST_FOCUS_TH);
    d += queue_event(KIND_SAMPLE, 0, 512, 0, 1'b0);         // sample in digital mode: dropped
    d += queue_event(KIND_TICK, 3, 0, 0, 1'b0);             // same pedal, acked: LED on
    d += queue_event(KIND_TICK, 0, 0, 0, 1'b0);             // change: restart
    d += queue_event(KIND_TX_READY, 0, 0, 0, 1'b0);
    d += queue_event(KIND_TICK, 1, 0, 0, 1'b0);             // restart in the middle of a send
    d += queue_event(KIND_TX_READY, 0, 0, 0, 1'b0);
    d += queue_event(KIND_TX_READY, 0, 0, 0, 1'b0);
    d += queue_event(KIND_TX_READY, 0, 0, 0, 1'b0);
    d += queue_event(KIND_RX, 0, 0, SYNC_BYTE, 1'b0);
    d += queue_event(KIND_RX, 0, 0, 0, 1'b1);
    d += queue_event(KIND_TICK, 1, 0, 0, 1'b0);
    d += queue_event(KIND_TICK, 2, 0, 0, 1'b0);
    d += queue_event(KIND_TX_READY, 0, 0, 0, 1'b0);
    d += queue_event(KIND_TX_READY, 0, 0, 0, 1'b0);
    wait_drained();

    // Random phases over a spread of register settings, extremes among them
    set_regs(1'b1, 0, 64, 110);
    fill_phase(145);
    wait_drained();
    set_regs(1'b0, 255, 0, 255);                            // salt with low bits set
    fill_phase(160);
    wait_drained();
    set_regs(1'b1, 3, 255, 0);                              // thresholds in reverse order
    fill_phase(145);
    wait_drained();
    set_regs(1'b1, $urandom_range(0, 255), 0, 0);
    fill_phase(135);
    wait_drained();
    set_regs(1'b0, $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
    fill_phase(160);
    wait_drained();

    // Last stretch at full rate on both sides
    no_idle = 1;
    set_regs(1'b1, RST_SALT, $urandom_range(0, 130), $urandom_range(100, 255));
    fill_phase(145);
    wait_drained();
    repeat (5) @(posedge clk);

    $display("covered %0d requests, %0d results (%0d bytes sent), %0d register writes",
             n_items, n_results, n_sent, n_cfg);
    $display("beacon restarts %0d, LED settles %0d, acks %0d, drain pauses %0d",
             n_restart, n_settle, n_ack, n_drain);
    if (n_errors == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

`default_nettype wire
